// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/met_pkg.sv =====
package met_pkg;

  localparam int unsigned PixW   = 9;
  localparam int unsigned CoordW = 48;
  localparam int unsigned StepW  = 44;
  localparam int unsigned IterW  = 16;
  localparam int unsigned BoundW = 4;
  localparam int unsigned FracW  = 44;
  localparam int unsigned MagW   = 48;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned DataW  = 64;

  // register index codes (paddr[5:3])
  localparam logic [2:0] RegOriginRe  = 3'd0;
  localparam logic [2:0] RegOriginIm  = 3'd1;
  localparam logic [2:0] RegStepRe    = 3'd2;
  localparam logic [2:0] RegStepIm    = 3'd3;
  localparam logic [2:0] RegIterLimit = 3'd4;
  localparam logic [2:0] RegEscBound  = 3'd5;

  // reset values: -2.0 in Q4.44, step 1/120, limit 256, bound 4
  localparam logic [CoordW-1:0] OriginRst = 48'hE000_0000_0000;
  localparam logic [StepW-1:0]  StepRst   = 44'd146601550370;
  localparam logic [IterW-1:0]  LimitRst  = 16'd256;
  localparam logic [BoundW-1:0] BoundRst  = 4'd4;

  typedef struct packed {
    logic [PixW-1:0] pixel_col;
    logic [PixW-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [IterW-1:0] iteration_count;
    logic             escaped;
    logic [MagW-1:0]  final_magnitude_sq;
  } out_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_re;
    logic signed [CoordW-1:0] origin_im;
    logic [StepW-1:0]         step_re;
    logic [StepW-1:0]         step_im;
    logic [IterW-1:0]         iteration_limit;
    logic [BoundW-1:0]        escape_bound;
  } cfg_t;

  typedef struct packed {
    logic load_pix;
    logic map_mul;
    logic map_add;
    logic init_iter;
    logic step;
    logic abs_en;
    logic mul_en;
    logic sum_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic stop;
  } sts_t;

endpackage

// ===== hw/rtl/met_regs.sv =====
module met_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [met_pkg::AddrW-1:0] paddr,
  input  logic [met_pkg::DataW-1:0] pwdata,
  output logic [met_pkg::DataW-1:0] prdata,
  output logic                   pready,
  output met_pkg::cfg_t          cfg_o
);
  import met_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_re       <= OriginRst;
      cfg_q.origin_im       <= OriginRst;
      cfg_q.step_re         <= StepRst;
      cfg_q.step_im         <= StepRst;
      cfg_q.iteration_limit <= LimitRst;
      cfg_q.escape_bound    <= BoundRst;
    end else if (wr_en) begin
      unique case (idx)
        RegOriginRe:  cfg_q.origin_re       <= pwdata[CoordW-1:0];
        RegOriginIm:  cfg_q.origin_im       <= pwdata[CoordW-1:0];
        RegStepRe:    cfg_q.step_re         <= pwdata[StepW-1:0];
        RegStepIm:    cfg_q.step_im         <= pwdata[StepW-1:0];
        RegIterLimit: cfg_q.iteration_limit <= pwdata[IterW-1:0];
        RegEscBound:  cfg_q.escape_bound    <= pwdata[BoundW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegOriginRe:  prdata = DataW'(unsigned'(cfg_q.origin_re));
      RegOriginIm:  prdata = DataW'(unsigned'(cfg_q.origin_im));
      RegStepRe:    prdata = DataW'(cfg_q.step_re);
      RegStepIm:    prdata = DataW'(cfg_q.step_im);
      RegIterLimit: prdata = DataW'(cfg_q.iteration_limit);
      RegEscBound:  prdata = DataW'(cfg_q.escape_bound);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/met_ctrl.sv =====
`include "assert_macros.svh"

module met_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  met_pkg::sts_t sts_i,
  output met_pkg::cmd_t cmd_o
);
  import met_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAPM = 3'd1;
  localparam logic [2:0] S_MAPA = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_ABS  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_pix = 1'b1;
          state_d        = S_MAPM;
        end
      end
      S_MAPM: begin
        cmd_o.map_mul = 1'b1;
        state_d       = S_MAPA;
      end
      S_MAPA: begin
        cmd_o.map_add   = 1'b1;
        cmd_o.init_iter = 1'b1;
        state_d         = S_CHK;
      end
      S_CHK: begin
        if (sts_i.stop) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_ABS;
        end
      end
      S_ABS: begin
        cmd_o.abs_en = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = S_CHK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_CLK(a_load_out_free, cmd_o.load_out |-> (!out_valid_q || !out_stall_i), "result overwritten")
  `ASSERT_NEXT(a_load_sets_valid, cmd_o.load_out, out_valid_q, "loaded result not shown")
  `ASSERT_NEXT(a_accept_maps, (in_valid_i && state_q == S_IDLE), state_q == S_MAPM, "accept lost")

endmodule

// ===== hw/rtl/met_dp.sv =====
module met_dp #(
  parameter int unsigned IMAGE_SIZE = 512
) (
  input  logic               clk_i,
  input  met_pkg::cfg_t      cfg_i,
  input  met_pkg::in_word_t  in_data_i,
  input  met_pkg::cmd_t      cmd_i,
  output met_pkg::sts_t      sts_o,
  output met_pkg::out_word_t out_data_o
);
  import met_pkg::*;

  localparam int unsigned LimW  = $clog2(IMAGE_SIZE + 1);
  localparam int unsigned CmpW  = (LimW > PixW) ? LimW : PixW;
  localparam logic [CmpW-1:0] ImgLim = CmpW'(IMAGE_SIZE);
  localparam logic [PixW-1:0] ImgMax = PixW'(IMAGE_SIZE - 1);
  localparam int unsigned ProdW = StepW + PixW;   // step * index
  localparam int unsigned SqW   = 51;             // re^2, im^2 <= 2^50
  localparam int unsigned WW    = 53;             // (re+im)^2 <= 2^52
  localparam int unsigned UW    = 49;             // |re+im| <= 2^48
  localparam int unsigned HalfW = 24;
  localparam int unsigned WideW = 56;

  localparam logic signed [WideW-1:0] Max48 = 56'sd140737488355327;
  localparam logic signed [WideW-1:0] Min48 = -56'sd140737488355328;

  function automatic logic [PixW-1:0] clamp_idx(input logic [PixW-1:0] v);
    if (CmpW'(v) >= ImgLim) return ImgMax;
    return v;
  endfunction

  function automatic logic signed [CoordW-1:0] sat48(input logic signed [WideW-1:0] v);
    if (v > Max48) return Max48[CoordW-1:0];
    if (v < Min48) return Min48[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

  function automatic logic [UW-1:0] abs49(input logic signed [UW-1:0] v);
    return v[UW-1] ? UW'(-v) : UW'(v);
  endfunction

  // floor(u^2 / 2^44) from the three partial products of u = a*2^24 + b
  function automatic logic [54:0] sq_q44(input logic [49:0] aa, input logic [48:0] ab,
                                         input logic [47:0] bb);
    logic [98:0] full;
    full = (99'(aa) << 48) + (99'(ab) << 25) + 99'(bb);
    return full[98:FracW];
  endfunction

  logic [PixW-1:0]          col_q, row_q;
  logic [ProdW-1:0]         prod_re_q, prod_im_q;
  logic signed [CoordW-1:0] c_re_q, c_im_q, re_q, im_q;
  logic [2:0][UW-1:0]       u_q;
  logic [2:0][49:0]         aa_q;
  logic [2:0][48:0]         ab_q;
  logic [2:0][47:0]         bb_q;
  logic [SqW-1:0]           re2_q, im2_q;
  logic [WW-1:0]            w_q;
  logic [IterW-1:0]         iter_q;
  out_word_t                out_q;

  logic [SqW:0]             mag_sum;
  logic [SqW:0]             bound;
  logic signed [WideW-1:0]  cre_wide, cim_wide, re_wide, im_wide;
  logic signed [UW-1:0]     s_wide;
  logic [2:0][54:0]         sq;

  assign mag_sum = {1'b0, re2_q} + {1'b0, im2_q};
  assign bound   = (SqW + 1)'({cfg_i.escape_bound, {FracW{1'b0}}});
  assign sts_o.stop = (mag_sum > bound) || (iter_q >= cfg_i.iteration_limit);

  assign cre_wide = {{(WideW-CoordW){cfg_i.origin_re[CoordW-1]}}, cfg_i.origin_re}
                  + $signed({{(WideW-ProdW){1'b0}}, prod_re_q});
  assign cim_wide = {{(WideW-CoordW){cfg_i.origin_im[CoordW-1]}}, cfg_i.origin_im}
                  + $signed({{(WideW-ProdW){1'b0}}, prod_im_q});
  assign re_wide  = $signed({{(WideW-SqW){1'b0}}, re2_q}) - $signed({{(WideW-SqW){1'b0}}, im2_q})
                  + {{(WideW-CoordW){c_re_q[CoordW-1]}}, c_re_q};
  assign im_wide  = $signed({{(WideW-WW){1'b0}}, w_q}) - $signed({{(WideW-SqW){1'b0}}, re2_q})
                  - $signed({{(WideW-SqW){1'b0}}, im2_q})
                  + {{(WideW-CoordW){c_im_q[CoordW-1]}}, c_im_q};
  assign s_wide   = {re_q[CoordW-1], re_q} + {im_q[CoordW-1], im_q};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq[k] = sq_q44(aa_q[k], ab_q[k], bb_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      col_q <= clamp_idx(in_data_i.pixel_col);
      row_q <= clamp_idx(in_data_i.pixel_row);
    end
    if (cmd_i.map_mul) begin
      prod_re_q <= ProdW'(cfg_i.step_re) * ProdW'(col_q);
      prod_im_q <= ProdW'(cfg_i.step_im) * ProdW'(row_q);
    end
    if (cmd_i.map_add) begin
      c_re_q <= sat48(cre_wide);
      c_im_q <= sat48(cim_wide);
    end
    if (cmd_i.init_iter) begin
      re2_q  <= '0;
      im2_q  <= '0;
      w_q    <= '0;
      iter_q <= '0;
    end
    if (cmd_i.step) begin
      re_q   <= sat48(re_wide);
      im_q   <= sat48(im_wide);
      iter_q <= iter_q + 1'b1;
    end
    if (cmd_i.abs_en) begin
      u_q[0] <= abs49({re_q[CoordW-1], re_q});
      u_q[1] <= abs49({im_q[CoordW-1], im_q});
      u_q[2] <= abs49(s_wide);
    end
    if (cmd_i.mul_en) begin
      for (int k = 0; k < 3; k++) begin
        aa_q[k] <= 50'(u_q[k][UW-1:HalfW]) * 50'(u_q[k][UW-1:HalfW]);
        ab_q[k] <= 49'(u_q[k][UW-1:HalfW]) * 49'(u_q[k][HalfW-1:0]);
        bb_q[k] <= 48'(u_q[k][HalfW-1:0]) * 48'(u_q[k][HalfW-1:0]);
      end
    end
    if (cmd_i.sum_en) begin
      re2_q <= sq[0][SqW-1:0];
      im2_q <= sq[1][SqW-1:0];
      w_q   <= sq[2][WW-1:0];
    end
    if (cmd_i.load_out) begin
      out_q.iteration_count    <= iter_q;
      out_q.escaped            <= (iter_q < cfg_i.iteration_limit);
      out_q.final_magnitude_sq <= mag_sum[SqW:4];
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/mandelbrot_escape_time_unit.sv =====
// Mandelbrot escape-time unit. Each input word carries a pixel column and row
// (clamped to IMAGE_SIZE-1); the point c = origin + step*index is formed in
// signed Q4.44 and z = z*z + c is iterated from zero until re^2+im^2 exceeds
// escape_bound or iteration_limit iterations are done. One result word per
// pixel: iteration count, escaped flag, final re^2+im^2 in Q8.40. Timing: one
// pixel at a time: accept, map multiply, map add, then per iteration the
// squaring path (sum/saturate, absolute value, a bank of 25/24-bit
// partial-product multipliers, the product sum); a final check loads the
// result word once the output is free. The next pixel is accepted as soon
// as the result word is registered, even if the downstream still stalls it.
// Configuration through the APB port at byte address 8*i, 64-bit data;
// write it only while the unit is idle.
module mandelbrot_escape_time_unit #(
  parameter int unsigned IMAGE_SIZE = 512
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // pixel words in
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  met_pkg::in_word_t         in_data_i,
  // result words out
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output met_pkg::out_word_t        out_data_o,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [met_pkg::AddrW-1:0] paddr,
  input  logic [met_pkg::DataW-1:0] pwdata,
  output logic [met_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import met_pkg::*;

  cfg_t cfg;   // live register values
  cmd_t cmd;   // controller -> datapath
  sts_t sts;   // datapath -> controller

  met_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: accept, map, iterate, hand off the result word
  met_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // coordinate mapping, orbit registers, squarers and result register
  met_dp #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== test/escape_time_checker.sv =====
module escape_time_checker #(
  parameter int unsigned IMAGE_SIZE = 512
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  met_pkg::in_word_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  met_pkg::out_word_t        out_data_i,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [met_pkg::AddrW-1:0] paddr,
  input  logic [met_pkg::DataW-1:0] pwdata,
  input  logic                      pready,
  output int                        fail_count_o,
  output int                        pending_o
);
  import met_pkg::*;

  localparam longint CoordMax = (longint'(1) <<< (CoordW - 1)) - 1;
  localparam longint CoordMin = -(longint'(1) <<< (CoordW - 1));
  localparam logic [63:0] MagMax = (64'd1 << MagW) - 1;

  cfg_t      view_cfg;
  out_word_t expected_results_q[$];

  function automatic longint sat_coord(longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  // floor(x*x / 2^44), exact
  function automatic logic [63:0] square_q44(longint x);
    logic [63:0]  u;
    logic [127:0] p;
    u = (x < 0) ? 64'(-x) : 64'(x);
    p = {64'd0, u} * {64'd0, u};
    return p[FracW+63:FracW];
  endfunction

  function automatic out_word_t predict_escape(in_word_t px, cfg_t cfg);
    longint      col, row, c_re, c_im, re, im;
    logic [63:0] re2, im2, w, bound, mag;
    int unsigned iter;
    out_word_t   r;
    col = (px.pixel_col >= IMAGE_SIZE) ? longint'(IMAGE_SIZE - 1) : longint'(px.pixel_col);
    row = (px.pixel_row >= IMAGE_SIZE) ? longint'(IMAGE_SIZE - 1) : longint'(px.pixel_row);
    c_re = sat_coord(longint'($signed(cfg.origin_re)) + longint'(cfg.step_re) * col);
    c_im = sat_coord(longint'($signed(cfg.origin_im)) + longint'(cfg.step_im) * row);
    bound = 64'(cfg.escape_bound) << FracW;
    re2 = '0;
    im2 = '0;
    w = '0;
    iter = 0;
    while ((re2 + im2) <= bound && iter < cfg.iteration_limit) begin
      re = sat_coord(longint'(re2) - longint'(im2) + c_re);
      im = sat_coord(longint'(w) - longint'(re2) - longint'(im2) + c_im);
      re2 = square_q44(re);
      im2 = square_q44(im);
      w = square_q44(re + im);
      iter++;
    end
    mag = (re2 + im2) >> 4;
    if (mag > MagMax) mag = MagMax;
    r.iteration_count = iter[IterW-1:0];
    r.escaped = (iter < cfg.iteration_limit);
    r.final_magnitude_sq = mag[MagW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      view_cfg.origin_re = OriginRst;
      view_cfg.origin_im = OriginRst;
      view_cfg.step_re = StepRst;
      view_cfg.step_im = StepRst;
      view_cfg.iteration_limit = LimitRst;
      view_cfg.escape_bound = BoundRst;
      expected_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:3])
          RegOriginRe:  view_cfg.origin_re = pwdata[CoordW-1:0];
          RegOriginIm:  view_cfg.origin_im = pwdata[CoordW-1:0];
          RegStepRe:    view_cfg.step_re = pwdata[StepW-1:0];
          RegStepIm:    view_cfg.step_im = pwdata[StepW-1:0];
          RegIterLimit: view_cfg.iteration_limit = pwdata[IterW-1:0];
          RegEscBound:  view_cfg.escape_bound = pwdata[BoundW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_results_q.push_back(predict_escape(in_data_i, view_cfg));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          $error("result word with none expected");
          fail_count_o++;
        end else begin
          want = expected_results_q.pop_front();
          if (out_data_i.iteration_count !== want.iteration_count) begin
            $error("iteration_count: expected %0d, actual %0d",
                   want.iteration_count, out_data_i.iteration_count);
            fail_count_o++;
          end
          if (out_data_i.escaped !== want.escaped) begin
            $error("escaped: expected %0d, actual %0d", want.escaped, out_data_i.escaped);
            fail_count_o++;
          end
          if (out_data_i.final_magnitude_sq !== want.final_magnitude_sq) begin
            $error("final_magnitude_sq: expected %h, actual %h",
                   want.final_magnitude_sq, out_data_i.final_magnitude_sq);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

// ===== test/tb_mandelbrot_escape_time_unit.sv =====
module tb_mandelbrot_escape_time_unit;
  import met_pkg::*;

  // addresses past the register map; writes there must be dropped
  localparam logic [2:0] RegUnmapped0 = 3'd6;
  localparam logic [2:0] RegUnmapped1 = 3'd7;

  localparam int PixelsPerPhase = 50;
  localparam int RandomPhases   = 29;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_word_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_word_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  int fail_count;
  int pending_words;
  // idle odds in percent per cycle, changed between phases
  int tx_idle_pct;
  int rx_stall_pct;

  // 10-unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mandelbrot_escape_time_unit #(.IMAGE_SIZE(512)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predicts every accepted pixel and scores every accepted result
  escape_time_checker #(.IMAGE_SIZE(512)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  // downstream stall, redrawn each falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // watchdog: far above the slowest legal run (every pixel at 256
  // iterations, plus idle gaps and stalls)
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic in_word_t pix(int col, int row);
    in_word_t w;
    w.pixel_col = col[PixW-1:0];
    w.pixel_row = row[PixW-1:0];
    return w;
  endfunction

  // setup cycle, then access cycle; pready is honored even though tied high
  task automatic write_reg(logic [2:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // writes all six registers; unused upper data bits carry junk
  task automatic program_view(logic [CoordW-1:0] ore, logic [CoordW-1:0] oim,
                              logic [StepW-1:0] sre, logic [StepW-1:0] sim,
                              logic [IterW-1:0] lim, logic [BoundW-1:0] bnd);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(RegOriginRe, {junk[15:0], ore});
    junk = $urandom;
    write_reg(RegOriginIm, {junk[15:0], oim});
    junk = $urandom;
    write_reg(RegStepRe, {junk[19:0], sre});
    junk = $urandom;
    write_reg(RegStepIm, {junk[19:0], sim});
    junk = $urandom;
    write_reg(RegIterLimit, {junk, junk[15:0], lim});
    junk = $urandom;
    write_reg(RegEscBound, {junk, junk[27:0], bnd});
  endtask

  // one pixel word; valid stays high afterwards so back-to-back words
  // never see valid dropped and raised in the same step
  task automatic send_pixel(in_word_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every predicted result to be consumed
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_words != 0) @(negedge clk_i);
  endtask

  task automatic program_random_view();
    logic [CoordW-1:0] ore, oim;
    logic [StepW-1:0]  sre, sim;
    logic [IterW-1:0]  lim;
    logic [BoundW-1:0] bnd;
    int                kind;
    kind = $urandom_range(0, 9);
    // usual window: origin in [-2.5, 1.0], step up to 2^-7 per pixel
    ore = CoordW'(longint'($urandom_range(0, 3500)) * (longint'(1) <<< FracW) / 1000
                  - (longint'(5) <<< (FracW - 1)));
    oim = CoordW'(longint'($urandom_range(0, 3500)) * (longint'(1) <<< FracW) / 1000
                  - (longint'(5) <<< (FracW - 1)));
    sre = StepW'({$urandom, $urandom} >> 27);
    sim = StepW'({$urandom, $urandom} >> 27);
    lim = IterW'($urandom_range(1, 48));
    bnd = BoundW'($urandom_range(0, 15));
    case (kind)
      0: lim = '0;
      1: begin
        // c_re pinned at the top: every orbit leaves on the first step,
        // so the widest limit stays cheap
        ore = {1'b0, {(CoordW-1){1'b1}}};
        oim = CoordW'({$urandom, $urandom});
        lim = '1;
      end
      2: lim = IterW'($urandom_range(100, 256));
      3: begin
        ore = CoordW'({$urandom, $urandom});
        oim = CoordW'({$urandom, $urandom});
        sre = StepW'({$urandom, $urandom});
        sim = StepW'({$urandom, $urandom});
      end
      4: begin
        ore = {1'b1, {(CoordW-1){1'b0}}};
        sre = StepW'({$urandom, $urandom});
      end
      default: ;
    endcase
    program_view(ore, oim, sre, sim, lim, bnd);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle_pct = 29;
    rx_stall_pct = 87;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // --- directed ---
    // reset view: corners, bit patterns, c = 0 and c = -1 stay bounded
    // for the full 256 steps, c = 0.75 escapes
    send_pixel(pix(0, 0));
    send_pixel(pix(511, 511));
    send_pixel(pix(0, 511));
    send_pixel(pix(511, 0));
    send_pixel(pix(9'h155, 9'h0AA));
    send_pixel(pix(240, 240));
    send_pixel(pix(120, 240));
    send_pixel(pix(330, 240));
    drain();

    // limit of one: c = -2-2i crosses the bound exactly on the last step
    program_view(OriginRst, OriginRst, StepRst, StepRst, 16'd1, BoundRst);
    send_pixel(pix(0, 0));
    send_pixel(pix(240, 240));
    send_pixel(pix(511, 511));
    drain();

    // zero limit: nothing iterates
    program_view(OriginRst, OriginRst, StepRst, StepRst, 16'd0, 4'd0);
    send_pixel(pix(0, 0));
    send_pixel(pix(511, 511));
    drain();

    // zero bound: c = 0 holds at zero, anything else escapes at once
    program_view('0, '0, StepRst, StepRst, 16'd3, 4'd0);
    send_pixel(pix(0, 0));
    send_pixel(pix(1, 0));
    send_pixel(pix(0, 1));
    drain();

    // low extremes: most negative origin, zero step
    program_view({1'b1, {(CoordW-1){1'b0}}}, {1'b1, {(CoordW-1){1'b0}}}, '0, '0,
                 16'd2, 4'd1);
    send_pixel(pix(0, 0));
    send_pixel(pix(511, 511));
    drain();

    // high extremes: c saturates, widest limit, largest bound
    program_view({1'b0, {(CoordW-1){1'b1}}}, {1'b0, {(CoordW-1){1'b1}}}, '1, '1,
                 16'hFFFF, 4'hF);
    send_pixel(pix(0, 0));
    send_pixel(pix(511, 511));
    send_pixel(pix(511, 0));
    drain();

    // writes past the map are dropped; view goes back to the reset one
    program_view(OriginRst, OriginRst, StepRst, StepRst, LimitRst, BoundRst);
    write_reg(RegUnmapped0, {$urandom, $urandom});
    write_reg(RegUnmapped1, {$urandom, $urandom});
    send_pixel(pix(100, 200));
    send_pixel(pix(300, 400));
    drain();

    // --- random phases: new view each phase, idle pattern by thirds ---
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph < RandomPhases / 3) begin
        tx_idle_pct = 29;
        rx_stall_pct = 87;
      end else if (ph < 2 * RandomPhases / 3) begin
        tx_idle_pct = 87;
        rx_stall_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      program_random_view();
      for (int n = 0; n < PixelsPerPhase; n++)
        send_pixel(pix($urandom_range(0, 511), $urandom_range(0, 511)));
      drain();
    end

    // short tail for any late stray result word
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
